// ===== design/pwt_pkg.sv =====
// Shared types and codes for the protobuf wire tokenizer.
// Depends on nothing; every other design file imports it.
`default_nettype none

package pwt_pkg;

    // Token kinds on the result channel
    localparam logic [1:0] KIND_SCALAR  = 2'd0;
    localparam logic [1:0] KIND_LENGTH  = 2'd1;
    localparam logic [1:0] KIND_PAYLOAD = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    // Error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_GROUP     = 3'd1;
    localparam logic [2:0] ERR_UNDEF     = 3'd2;
    localparam logic [2:0] ERR_TRUNC     = 3'd3;
    localparam logic [2:0] ERR_LONG      = 3'd4;
    localparam logic [2:0] ERR_LEN_RANGE = 3'd5;

    // Wire types carried in the low three key bits
    localparam logic [2:0] TYPE_VARINT  = 3'd0;
    localparam logic [2:0] TYPE_FIX64   = 3'd1;
    localparam logic [2:0] TYPE_LENGTH  = 3'd2;
    localparam logic [2:0] TYPE_GSTART  = 3'd3;
    localparam logic [2:0] TYPE_GEND    = 3'd4;
    localparam logic [2:0] TYPE_FIX32   = 3'd5;

    localparam int ACC_BITS   = 112;
    localparam int FIELD_BITS = 29;

    // One classified input byte as it travels from front to back
    typedef struct packed {
        logic [7:0] data;
        logic [6:0] group;
        logic       cont;
        logic       msg_end;
    } pwt_item_t;

endpackage

`default_nettype wire

// ===== design/pwt_front.sv =====
// Input stage of the tokenizer: registers each accepted byte and splits it
// into varint group and continuation flag. Uses pwt_pkg.
`default_nettype none

module pwt_front
    import pwt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] data_byte,
    input  wire logic       message_end,
    output logic            push_valid,
    input  wire logic       push_ready,
    output pwt_item_t       push_item
);

    logic      stage_valid_reg;
    logic      stage_valid_next;
    pwt_item_t stage_item_reg;
    logic      take;

    assign in_ready   = !stage_valid_reg || push_ready;
    assign take       = in_valid && in_ready;
    assign push_valid = stage_valid_reg;
    assign push_item  = stage_item_reg;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (take)
        begin
            stage_valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            stage_item_reg.data    <= data_byte;
            stage_item_reg.group   <= data_byte[6:0];
            stage_item_reg.cont    <= data_byte[7];
            stage_item_reg.msg_end <= message_end;
        end
    end

endmodule

`default_nettype wire

// ===== design/pwt_queue.sv =====
// Two-entry queue of classified bytes between front and back.
// Uses pwt_pkg for the item type.
`default_nettype none

module pwt_queue
    import pwt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push_valid,
    output logic            push_ready,
    input  wire pwt_item_t  push_item,
    output logic            pop_valid,
    input  wire logic       pop_ready,
    output pwt_item_t       pop_item
);

    localparam int DEPTH = 2;

    pwt_item_t  mem [DEPTH];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != 2'(DEPTH));
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_item   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ===== design/pwt_back.sv =====
// Token engine: walks the key/value phases one byte per cycle unless a held token
// stalls it, and holds the finished token in an output register. Uses pwt_pkg.
`default_nettype none

module pwt_back
    import pwt_pkg::*;
#(
    parameter int MAX_VARINT_BYTES = 16,
    parameter int LENGTH_BITS      = 32
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         pop_valid,
    output logic              pop_ready,
    input  wire pwt_item_t    pop_item,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [1:0]        kind,
    output logic [28:0]       field_number,
    output logic [2:0]        key_type,
    output logic [63:0]       value_low,
    output logic [47:0]       value_high,
    output logic [63:0]       zigzag_magnitude,
    output logic              zigzag_negative,
    output logic [7:0]        payload_byte,
    output logic              payload_last,
    output logic [2:0]        error_code,
    output logic              message_done
);

    localparam logic [63:0] LEN_LIMIT =
        (LENGTH_BITS >= 64) ? {64{1'b1}} : ((64'd1 << LENGTH_BITS) - 64'd1);

    typedef enum logic [2:0] {
        PH_KEY     = 3'd0,
        PH_VARINT  = 3'd1,
        PH_FIX64   = 3'd2,
        PH_LENGTH  = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_FIX32   = 3'd5,
        PH_DISCARD = 3'd6
    } phase_t;

    phase_t                  phase_reg, phase_next;
    logic [ACC_BITS-1:0]     acc_reg, acc_next;
    logic [3:0]              idx_reg, idx_next;
    logic [FIELD_BITS-1:0]   field_reg, field_next;
    logic [2:0]              wtype_reg, wtype_next;
    logic [LENGTH_BITS-1:0]  rem_reg, rem_next;

    logic                    out_valid_reg, out_valid_next;
    logic [1:0]              kind_reg;
    logic [28:0]             field_out_reg;
    logic [2:0]              wtype_out_reg;
    logic [63:0]             low_reg;
    logic [47:0]             high_reg;
    logic [63:0]             mag_reg;
    logic                    neg_reg;
    logic [7:0]              pbyte_reg;
    logic                    plast_reg;
    logic [2:0]              err_reg;
    logic                    done_reg;

    logic                    fire;
    logic [6:0]              grp_shamt;
    logic [ACC_BITS-1:0]     acc_add;
    logic [63:0]             fix_low;
    logic [4:0]              idx_inc;
    logic                    too_long;
    logic                    fix_done;
    logic [64:0]             zz_sum;
    logic [63:0]             zz_mag;
    logic                    len_bad;
    logic [LENGTH_BITS-1:0]  rem_dec;
    logic                    pay_last;

    logic                    emit;
    logic                    err_hit;
    logic [2:0]              err_code;
    logic [1:0]              r_kind;
    logic [63:0]             r_low;
    logic [47:0]             r_high;
    logic [63:0]             r_mag;
    logic                    r_neg;
    logic [7:0]              r_pbyte;
    logic                    r_plast;

    assign pop_ready = !out_valid_reg || out_ready;
    assign fire      = pop_valid && pop_ready;

    // Varint group i lands at bit 7*i of the 112-bit accumulator
    assign grp_shamt = ({3'b000, idx_reg} << 3) - {3'b000, idx_reg};
    assign acc_add   = acc_reg | (ACC_BITS'(pop_item.group) << grp_shamt);
    assign fix_low   = acc_reg[63:0] | (64'(pop_item.data) << {idx_reg[2:0], 3'b000});
    assign idx_inc   = {1'b0, idx_reg} + 5'd1;
    assign too_long  = (idx_inc >= 5'(MAX_VARINT_BYTES));
    assign fix_done  = (phase_reg == PH_FIX64) ? (idx_inc >= 5'd8) : (idx_inc >= 5'd4);

    // Zig-zag: (value + sign) >> 1 with the carry rippled into bit 64
    assign zz_sum = {1'b0, acc_add[63:0]} + 65'(acc_add[0]);
    assign zz_mag = {acc_add[64] ^ zz_sum[64], zz_sum[63:1]};

    assign len_bad  = (acc_add[ACC_BITS-1:64] != '0) || ((acc_add[63:0] & ~LEN_LIMIT) != 64'd0);
    assign rem_dec  = (rem_reg != '0) ? (rem_reg - LENGTH_BITS'(1)) : rem_reg;
    assign pay_last = (rem_dec == '0);

    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        idx_next   = idx_reg;
        field_next = field_reg;
        wtype_next = wtype_reg;
        rem_next   = rem_reg;
        emit       = 1'b0;
        err_hit    = 1'b0;
        err_code   = ERR_NONE;
        r_kind     = KIND_SCALAR;
        r_low      = 64'd0;
        r_high     = 48'd0;
        r_mag      = 64'd0;
        r_neg      = 1'b0;
        r_pbyte    = 8'd0;
        r_plast    = 1'b0;

        case (phase_reg)
            PH_KEY, PH_VARINT, PH_LENGTH:
            begin
                if (phase_reg == PH_KEY)
                begin
                    field_next = '0;
                    wtype_next = 3'd0;
                end
                acc_next = acc_add;
                if (pop_item.cont)
                begin
                    if (too_long)
                    begin
                        err_hit  = 1'b1;
                        err_code = ERR_LONG;
                    end
                    else if (pop_item.msg_end)
                    begin
                        err_hit  = 1'b1;
                        err_code = ERR_TRUNC;
                    end
                    else
                    begin
                        idx_next = idx_inc[3:0];
                    end
                end
                else if (phase_reg == PH_KEY)
                begin
                    field_next = acc_add[FIELD_BITS+2:3];
                    wtype_next = acc_add[2:0];
                    acc_next   = '0;
                    idx_next   = 4'd0;
                    if (acc_add[2:0] == TYPE_GSTART || acc_add[2:0] == TYPE_GEND)
                    begin
                        err_hit  = 1'b1;
                        err_code = ERR_GROUP;
                    end
                    else if (acc_add[2:1] == 2'b11)
                    begin
                        err_hit  = 1'b1;
                        err_code = ERR_UNDEF;
                    end
                    else if (pop_item.msg_end)
                    begin
                        err_hit  = 1'b1;
                        err_code = ERR_TRUNC;
                    end
                    else
                    begin
                        case (acc_add[2:0])
                            TYPE_VARINT: phase_next = PH_VARINT;
                            TYPE_FIX64:  phase_next = PH_FIX64;
                            TYPE_LENGTH: phase_next = PH_LENGTH;
                            default:     phase_next = PH_FIX32;
                        endcase
                    end
                end
                else if (phase_reg == PH_VARINT)
                begin
                    emit       = 1'b1;
                    r_kind     = KIND_SCALAR;
                    r_low      = acc_add[63:0];
                    r_high     = acc_add[ACC_BITS-1:64];
                    r_mag      = zz_mag;
                    r_neg      = acc_add[0];
                    acc_next   = '0;
                    idx_next   = 4'd0;
                    phase_next = PH_KEY;
                end
                else
                begin
                    if (len_bad)
                    begin
                        err_hit  = 1'b1;
                        err_code = ERR_LEN_RANGE;
                    end
                    else if (pop_item.msg_end && acc_add[63:0] != 64'd0)
                    begin
                        err_hit  = 1'b1;
                        err_code = ERR_TRUNC;
                    end
                    else
                    begin
                        emit       = 1'b1;
                        r_kind     = KIND_LENGTH;
                        r_low      = acc_add[63:0];
                        acc_next   = '0;
                        idx_next   = 4'd0;
                        rem_next   = acc_add[LENGTH_BITS-1:0];
                        phase_next = (acc_add[63:0] != 64'd0) ? PH_PAYLOAD : PH_KEY;
                    end
                end
            end
            PH_FIX64, PH_FIX32:
            begin
                acc_next[63:0] = fix_low;
                idx_next       = idx_inc[3:0];
                if (fix_done)
                begin
                    emit       = 1'b1;
                    r_kind     = KIND_SCALAR;
                    r_low      = fix_low;
                    acc_next   = '0;
                    idx_next   = 4'd0;
                    phase_next = PH_KEY;
                end
                else if (pop_item.msg_end)
                begin
                    err_hit  = 1'b1;
                    err_code = ERR_TRUNC;
                end
            end
            PH_PAYLOAD:
            begin
                rem_next = rem_dec;
                if (!pay_last && pop_item.msg_end)
                begin
                    err_hit  = 1'b1;
                    err_code = ERR_TRUNC;
                end
                else
                begin
                    emit    = 1'b1;
                    r_kind  = KIND_PAYLOAD;
                    r_pbyte = pop_item.data;
                    r_plast = pay_last;
                    if (pay_last || pop_item.msg_end)
                    begin
                        phase_next = PH_KEY;
                    end
                end
            end
            PH_DISCARD:
            begin
                if (pop_item.msg_end)
                begin
                    acc_next   = '0;
                    idx_next   = 4'd0;
                    phase_next = PH_KEY;
                end
            end
            default:
            begin
                phase_next = PH_KEY;
            end
        endcase

        // Error token: drop the partial value, then skip to message end
        if (err_hit)
        begin
            emit       = 1'b1;
            r_kind     = KIND_ERROR;
            r_low      = 64'd0;
            r_high     = 48'd0;
            r_mag      = 64'd0;
            r_neg      = 1'b0;
            r_pbyte    = 8'd0;
            r_plast    = 1'b0;
            acc_next   = '0;
            idx_next   = 4'd0;
            phase_next = pop_item.msg_end ? PH_KEY : PH_DISCARD;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_KEY;
            acc_reg       <= '0;
            idx_reg       <= 4'd0;
            field_reg     <= '0;
            wtype_reg     <= 3'd0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                phase_reg <= phase_next;
                acc_reg   <= acc_next;
                idx_reg   <= idx_next;
                field_reg <= field_next;
                wtype_reg <= wtype_next;
                rem_reg   <= rem_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && emit)
        begin
            kind_reg      <= r_kind;
            field_out_reg <= field_next;
            wtype_out_reg <= wtype_next;
            low_reg       <= r_low;
            high_reg      <= r_high;
            mag_reg       <= r_mag;
            neg_reg       <= r_neg;
            pbyte_reg     <= r_pbyte;
            plast_reg     <= r_plast;
            err_reg       <= err_code;
            done_reg      <= pop_item.msg_end;
        end
    end

    assign out_valid        = out_valid_reg;
    assign kind             = kind_reg;
    assign field_number     = field_out_reg;
    assign key_type         = wtype_out_reg;
    assign value_low        = low_reg;
    assign value_high       = high_reg;
    assign zigzag_magnitude = mag_reg;
    assign zigzag_negative  = neg_reg;
    assign payload_byte     = pbyte_reg;
    assign payload_last     = plast_reg;
    assign error_code       = err_reg;
    assign message_done     = done_reg;

endmodule

`default_nettype wire

// ===== design/protobuf_wire_tokenizer.sv =====
// Top level of the protobuf wire tokenizer: input stage, item queue and
// token engine. Depends on pwt_pkg, pwt_front, pwt_queue and pwt_back.
//
//  channel | signals                          | direction | carries
//  --------+----------------------------------+-----------+------------------------------
//  in      | in_valid / in_ready              | sink      | data_byte, message_end
//  out     | out_valid / out_ready            | source    | one token: kind ... message_done
//
// One byte per cycle sustained while out_ready stays high; a byte passes the input stage,
// a queue entry and the token engine on its way to the output register.
// The token engine handles every byte as it pops it from the queue; its output register sets the
// pace, and the two-entry queue absorbs short stalls on either side.
// Reset (rst_n low) empties the pipeline and returns to expecting a key.
// Bytes that make no token (key bytes, partial values) still pass through the token engine.
`default_nettype none

module protobuf_wire_tokenizer
    import pwt_pkg::*;
#(
    parameter int MAX_VARINT_BYTES = 16,
    parameter int LENGTH_BITS      = 32
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic [7:0]   data_byte,
    input  wire logic         message_end,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [1:0]        kind,
    output logic [28:0]       field_number,
    output logic [2:0]        key_type,
    output logic [63:0]       value_low,
    output logic [47:0]       value_high,
    output logic [63:0]       zigzag_magnitude,
    output logic              zigzag_negative,
    output logic [7:0]        payload_byte,
    output logic              payload_last,
    output logic [2:0]        error_code,
    output logic              message_done
);

    logic      push_valid;
    logic      push_ready;
    pwt_item_t push_item;
    logic      pop_valid;
    logic      pop_ready;
    pwt_item_t pop_item;

    pwt_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .message_end (message_end),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_item   (push_item)
    );

    pwt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    pwt_back #(
        .MAX_VARINT_BYTES (MAX_VARINT_BYTES),
        .LENGTH_BITS      (LENGTH_BITS)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .pop_valid        (pop_valid),
        .pop_ready        (pop_ready),
        .pop_item         (pop_item),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .kind             (kind),
        .field_number     (field_number),
        .key_type         (key_type),
        .value_low        (value_low),
        .value_high       (value_high),
        .zigzag_magnitude (zigzag_magnitude),
        .zigzag_negative  (zigzag_negative),
        .payload_byte     (payload_byte),
        .payload_last     (payload_last),
        .error_code       (error_code),
        .message_done     (message_done)
    );

endmodule

`default_nettype wire

// ===== design/pwt_checker.sv =====
// Port-level checks on the tokenizer's result channel, bound to the top level.
// Uses pwt_pkg for token kinds and error codes.
`default_nettype none

module pwt_checker
    import pwt_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [1:0]  kind,
    input wire logic [63:0] value_low,
    input wire logic [47:0] value_high,
    input wire logic        zigzag_negative,
    input wire logic [63:0] zigzag_magnitude,
    input wire logic [2:0]  error_code
);

    // Hold a stalled item
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("out_valid dropped while stalled");

    a_kind_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(kind) && $stable(value_low))
        else $error("stalled token changed");

    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((kind == KIND_ERROR) == (error_code != ERR_NONE)))
        else $error("error code does not match token kind");

    a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_PAYLOAD || kind == KIND_ERROR)
            |-> value_low == 64'd0 && zigzag_magnitude == 64'd0 && !zigzag_negative)
        else $error("payload or error token carries a value");

    a_length_narrow: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_LENGTH |-> value_high == 48'd0 && !zigzag_negative)
        else $error("length token has high bits set");

endmodule

bind protobuf_wire_tokenizer pwt_checker u_pwt_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .kind             (kind),
    .value_low        (value_low),
    .value_high       (value_high),
    .zigzag_negative  (zigzag_negative),
    .zigzag_magnitude (zigzag_magnitude),
    .error_code       (error_code)
);

`default_nettype wire
